### hdl/ter_pkg.sv
// Shared constants and types for the triangle edge-function rasteriser.
// No dependencies.
package ter_pkg;

  localparam int COORD_W   = 24;
  localparam int COLOUR_W  = 32;
  localparam int FOCAL_W   = 24;
  localparam int DIM_W     = 12;
  localparam int PIX_W     = 11;
  localparam int IDX_W     = 22;
  localparam int SCR_W     = 32;
  localparam int DIV_W     = 48;
  localparam int FRAC_BITS = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] MAX_SCREEN = 12'd2048;
  localparam logic signed [SCR_W-1:0] COORD_LIMIT = 32'sd1073741823;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [COORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic             rem_nz;
  } div_rsp_t;

endpackage

### hdl/ter_in_if.sv
// Input channel of the rasteriser: valid/ready plus one load or step item.
// Depends on ter_pkg.
interface ter_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   command;
  logic signed [ter_pkg::COORD_W-1:0]     vertex_a_x;
  logic signed [ter_pkg::COORD_W-1:0]     vertex_a_y;
  logic signed [ter_pkg::COORD_W-1:0]     vertex_a_z;
  logic signed [ter_pkg::COORD_W-1:0]     vertex_b_x;
  logic signed [ter_pkg::COORD_W-1:0]     vertex_b_y;
  logic signed [ter_pkg::COORD_W-1:0]     vertex_b_z;
  logic signed [ter_pkg::COORD_W-1:0]     vertex_c_x;
  logic signed [ter_pkg::COORD_W-1:0]     vertex_c_y;
  logic signed [ter_pkg::COORD_W-1:0]     vertex_c_z;
  logic [ter_pkg::COLOUR_W-1:0]           triangle_colour;

  modport source (output valid, command, vertex_a_x, vertex_a_y, vertex_a_z,
                  vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y,
                  vertex_c_z, triangle_colour, input ready);
  modport sink (input valid, command, vertex_a_x, vertex_a_y, vertex_a_z,
                vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y,
                vertex_c_z, triangle_colour, output ready);
endinterface

### hdl/ter_out_if.sv
// Output channel of the rasteriser: valid/ready plus one pixel result item.
// Depends on ter_pkg.
interface ter_out_if;
  logic                          valid;
  logic                          ready;
  logic [ter_pkg::PIX_W-1:0]     pixel_x;
  logic [ter_pkg::PIX_W-1:0]     pixel_y;
  logic [ter_pkg::IDX_W-1:0]     pixel_index;
  logic [ter_pkg::COLOUR_W-1:0]  pixel_colour;
  logic                          write_pixel;
  logic                          last;
  logic                          rejected;

  modport source (output valid, pixel_x, pixel_y, pixel_index, pixel_colour,
                  write_pixel, last, rejected, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_index, pixel_colour,
                write_pixel, last, rejected, output ready);
endinterface

### hdl/ter_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on ter_pkg.
module ter_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ter_pkg::div_req_t req_i,
  output ter_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(ter_pkg::DIV_W);

  logic                          busy_q, done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [ter_pkg::DIV_W-1:0]     quo_q;
  logic [ter_pkg::COORD_W-1:0]   rem_q, dvs_q;
  logic [ter_pkg::COORD_W:0]     rem_shift, rem_sub;
  logic                          ge;

  always_comb begin
    rem_shift = {rem_q, quo_q[ter_pkg::DIV_W-1]};
    ge        = rem_shift >= {1'b0, dvs_q};
    rem_sub   = rem_shift - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ter_pkg::DIV_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[ter_pkg::DIV_W-2:0], ge};
      rem_q <= ge ? rem_sub[ter_pkg::COORD_W-1:0] : rem_shift[ter_pkg::COORD_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
  assign rsp_o.rem_nz   = rem_q != '0;

endmodule

### hdl/triangle_edge_function_rasteriser_top.sv
// Triangle edge-function rasteriser, top level.
// Load item: 6 projections, each a multiply, a divider start, the divider shift steps,
// its done and a fixup, then a box step, after which the block is idle again.
// Rejected load: result registered at the accepting edge. A step item during a scan
// gives its result through the shared 33x33 multiplier; input waits for the result.
// Reset (async, active low) restores state and config registers, drops any running scan.
module triangle_edge_function_rasteriser_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ter_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ter_pkg::FOCAL_W-1:0]      cfg_data_i,
  ter_in_if.sink                           in_if,
  ter_out_if.source                        out_if
);

  localparam int SCR_W = ter_pkg::SCR_W;
  localparam int FB    = ter_pkg::FRAC_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DST  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIX  = 3'd4;
  localparam logic [2:0] ST_BOX  = 3'd5;
  localparam logic [2:0] ST_EDGE = 3'd6;

  // configuration registers
  logic [ter_pkg::FOCAL_W-1:0] focal_q;
  logic [ter_pkg::DIM_W-1:0]   width_q, height_q, eff_w, eff_h;

  logic [2:0] state_q;
  logic [2:0] vidx_q, cnt_q;

  // latched load operands
  logic signed [ter_pkg::COORD_W-1:0] coord_q [6];
  logic signed [ter_pkg::COORD_W-1:0] z_q [3];
  logic [ter_pkg::COLOUR_W-1:0]       fill_q;

  // projected vertices: x0 y0 x1 y1 x2 y2
  logic signed [SCR_W-1:0] sv_q [6];
  logic signed [SCR_W-1:0] minx_q, miny_q, maxx_q, maxy_q, sx_q, sy_q;
  logic                    scan_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] prod_q, acc_q;
  logic               covered_q;

  ter_pkg::div_req_t div_req;
  ter_pkg::div_rsp_t div_rsp;

  logic                         out_valid_q, out_write_q, out_last_q, out_rej_q;
  logic [ter_pkg::PIX_W-1:0]    out_x_q, out_y_q;
  logic [ter_pkg::IDX_W-1:0]    out_idx_q;
  logic [ter_pkg::COLOUR_W-1:0] out_col_q;

  logic in_acc, rej_load;
  logic signed [49:0] quo_s, sum_s, half_s;
  logic signed [SCR_W-1:0] proj_sat;
  logic signed [SCR_W-1:0] lox, loy, hix, hiy, bminx, bminy, bmaxx, bmaxy, wl, hl;
  logic signed [64:0] edge_v;
  logic signed [SCR_W-1:0] nx, ny;
  logic [ter_pkg::PIX_W-1:0] ix, iy;

  function automatic logic signed [32:0] sdiff(input logic signed [SCR_W-1:0] a,
                                               input logic signed [SCR_W-1:0] b);
    logic signed [32:0] r;
    r = {a[SCR_W-1], a} - {b[SCR_W-1], b};
    return r;
  endfunction

  assign eff_w = (width_q  > ter_pkg::MAX_SCREEN) ? ter_pkg::MAX_SCREEN : width_q;
  assign eff_h = (height_q > ter_pkg::MAX_SCREEN) ? ter_pkg::MAX_SCREEN : height_q;

  assign in_if.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign in_acc      = in_if.valid && in_if.ready;
  assign rej_load    = (in_if.vertex_a_z <= 0) || (in_if.vertex_b_z <= 0) ||
                       (in_if.vertex_c_z <= 0);

  assign ix = sx_q[FB +: ter_pkg::PIX_W];
  assign iy = sy_q[FB +: ter_pkg::PIX_W];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_MUL) begin
      mul_a = 33'(coord_q[vidx_q]);
      mul_b = $signed({9'b0, focal_q});
    end else begin
      unique case (cnt_q)
        3'd0: begin mul_a = sdiff(sv_q[2], sv_q[0]); mul_b = sdiff(sy_q, sv_q[1]); end
        3'd1: begin mul_a = sdiff(sv_q[3], sv_q[1]); mul_b = sdiff(sx_q, sv_q[0]); end
        3'd2: begin mul_a = sdiff(sv_q[4], sv_q[2]); mul_b = sdiff(sy_q, sv_q[3]); end
        3'd3: begin mul_a = sdiff(sv_q[5], sv_q[3]); mul_b = sdiff(sx_q, sv_q[2]); end
        3'd4: begin mul_a = sdiff(sv_q[0], sv_q[4]); mul_b = sdiff(sy_q, sv_q[5]); end
        3'd5: begin mul_a = sdiff(sv_q[1], sv_q[5]); mul_b = sdiff(sx_q, sv_q[4]); end
        3'd6: begin
          mul_a = $signed({22'b0, iy});
          mul_b = $signed({21'b0, eff_w});
        end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // divider request: magnitude of the product over depth
  assign div_req.start    = (state_q == ST_DST);
  assign div_req.dividend = prod_q[63] ? (ter_pkg::DIV_W)'(-prod_q[ter_pkg::DIV_W-1:0])
                                       : prod_q[ter_pkg::DIV_W-1:0];
  assign div_req.divisor  = z_q[vidx_q[2:1]];

  ter_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // floor the quotient, add the screen half, saturate
  always_comb begin
    quo_s = $signed({2'b0, div_rsp.quotient});
    if (prod_q[63]) begin
      quo_s = -quo_s - $signed({49'b0, div_rsp.rem_nz});
    end
    half_s = vidx_q[0] ? $signed({31'b0, eff_h[ter_pkg::DIM_W-1:1], {FB{1'b0}}})
                       : $signed({31'b0, eff_w[ter_pkg::DIM_W-1:1], {FB{1'b0}}});
    sum_s = quo_s + half_s;
    if (sum_s > 50'(ter_pkg::COORD_LIMIT)) begin
      proj_sat = ter_pkg::COORD_LIMIT;
    end else if (sum_s < -50'(ter_pkg::COORD_LIMIT)) begin
      proj_sat = -ter_pkg::COORD_LIMIT;
    end else begin
      proj_sat = sum_s[SCR_W-1:0];
    end
  end

  // bounding box, clamped to the screen with exclusive upper bound
  always_comb begin
    lox = (sv_q[0] < sv_q[2]) ? sv_q[0] : sv_q[2];
    lox = (lox < sv_q[4]) ? lox : sv_q[4];
    loy = (sv_q[1] < sv_q[3]) ? sv_q[1] : sv_q[3];
    loy = (loy < sv_q[5]) ? loy : sv_q[5];
    hix = (sv_q[0] > sv_q[2]) ? sv_q[0] : sv_q[2];
    hix = (hix > sv_q[4]) ? hix : sv_q[4];
    hiy = (sv_q[1] > sv_q[3]) ? sv_q[1] : sv_q[3];
    hiy = (hiy > sv_q[5]) ? hiy : sv_q[5];
    wl = $signed({12'b0, eff_w, {FB{1'b0}}});
    hl = $signed({12'b0, eff_h, {FB{1'b0}}});
    bminx = (lox < 0) ? '0 : lox;
    bminy = (loy < 0) ? '0 : loy;
    bmaxx = (hix > wl) ? wl : hix;
    bmaxy = (hiy > hl) ? hl : hiy;
  end

  assign edge_v = {acc_q[63], acc_q} - {prod_q[63], prod_q};
  assign nx = sx_q + SCR_W'(1 << FB);
  assign ny = sy_q + SCR_W'(1 << FB);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q  <= 24'd256;
      width_q  <= 12'd640;
      height_q <= 12'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ter_pkg::CFG_FOCAL:  focal_q  <= cfg_data_i;
        ter_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[ter_pkg::DIM_W-1:0];
        ter_pkg::CFG_HEIGHT: height_q <= cfg_data_i[ter_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vidx_q      <= '0;
      cnt_q       <= '0;
      scan_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
    end else begin
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_if.command == ter_pkg::CMD_LOAD) begin
              scan_q <= 1'b0;
              fill_q <= in_if.triangle_colour;
              if (rej_load) begin
                out_valid_q <= 1'b1;
              end else begin
                vidx_q  <= '0;
                state_q <= ST_MUL;
              end
            end else if (scan_q) begin
              cnt_q   <= '0;
              state_q <= ST_EDGE;
            end
          end
        end
        ST_MUL: state_q <= ST_DST;
        ST_DST: state_q <= ST_DIV;
        ST_DIV: if (div_rsp.done) state_q <= ST_FIX;
        ST_FIX: begin
          if (vidx_q == 3'd5) begin
            state_q <= ST_BOX;
          end else begin
            vidx_q  <= vidx_q + 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_BOX: begin
          // empty box: report last and start no scan
          if (bminx >= bmaxx || bminy >= bmaxy) begin
            out_valid_q <= 1'b1;
          end else begin
            scan_q <= 1'b1;
            sx_q   <= bminx;
            sy_q   <= bminy;
          end
          state_q <= ST_IDLE;
        end
        ST_EDGE: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 3'd7) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            // advance along the row, wrap to the next row at the box edge
            if (nx >= maxx_q) begin
              sx_q <= minx_q;
              sy_q <= ny;
              if (ny >= maxy_q) scan_q <= 1'b0;
            end else begin
              sx_q <= nx;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && in_if.command == ter_pkg::CMD_LOAD) begin
      coord_q[0] <= in_if.vertex_a_x;
      coord_q[1] <= in_if.vertex_a_y;
      coord_q[2] <= in_if.vertex_b_x;
      coord_q[3] <= in_if.vertex_b_y;
      coord_q[4] <= in_if.vertex_c_x;
      coord_q[5] <= in_if.vertex_c_y;
      z_q[0]     <= in_if.vertex_a_z;
      z_q[1]     <= in_if.vertex_b_z;
      z_q[2]     <= in_if.vertex_c_z;
    end
    if (in_acc && in_if.command == ter_pkg::CMD_STEP) begin
      covered_q <= 1'b1;
    end
    if (state_q == ST_MUL || (state_q == ST_EDGE && cnt_q != 3'd7)) begin
      prod_q <= mul_p[63:0];
    end
    if (state_q == ST_FIX) begin
      sv_q[vidx_q] <= proj_sat;
    end
    if (state_q == ST_BOX) begin
      minx_q <= bminx;
      miny_q <= bminy;
      maxx_q <= bmaxx;
      maxy_q <= bmaxy;
    end
    if (state_q == ST_EDGE && cnt_q != 3'd0 && cnt_q != 3'd7) begin
      // odd step holds the first product, even step closes an edge:
      // drop coverage on a negative edge value
      if (cnt_q[0]) begin
        acc_q <= prod_q;
      end else if (edge_v < 0) begin
        covered_q <= 1'b0;
      end
    end

    // result payload
    if (state_q == ST_IDLE && in_acc && in_if.command == ter_pkg::CMD_LOAD && rej_load) begin
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_idx_q   <= '0;
      out_col_q   <= '0;
      out_write_q <= 1'b0;
      out_last_q  <= 1'b1;
      out_rej_q   <= 1'b1;
    end else if (state_q == ST_BOX) begin
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_idx_q   <= '0;
      out_col_q   <= '0;
      out_write_q <= 1'b0;
      out_last_q  <= 1'b1;
      out_rej_q   <= 1'b0;
    end else if (state_q == ST_EDGE && cnt_q == 3'd7) begin
      out_x_q     <= ix;
      out_y_q     <= iy;
      out_idx_q   <= prod_q[ter_pkg::IDX_W-1:0] + {{(ter_pkg::IDX_W-ter_pkg::PIX_W){1'b0}}, ix};
      out_col_q   <= covered_q ? fill_q : '0;
      out_write_q <= covered_q;
      out_last_q  <= (nx >= maxx_q) && (ny >= maxy_q);
      out_rej_q   <= 1'b0;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.pixel_x      = out_x_q;
  assign out_if.pixel_y      = out_y_q;
  assign out_if.pixel_index  = out_idx_q;
  assign out_if.pixel_colour = out_col_q;
  assign out_if.write_pixel  = out_write_q;
  assign out_if.last         = out_last_q;
  assign out_if.rejected     = out_rej_q;

  // no item is taken while a result still waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |-> !out_valid_q)
    else $error("item accepted while a result is pending");

  // a rejected load always ends the triangle
  a_rej_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rej_q) |-> (out_last_q && !out_write_q))
    else $error("rejected result without last");

  // a running scan stays inside the clamped box, apart from the unchecked lower y bound
  a_scan_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_q && state_q == ST_IDLE) |->
      (sx_q >= minx_q && sx_q < maxx_q && sy_q < maxy_q))
    else $error("sample outside bounding box");

endmodule
